/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define MMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, held off during reset
`define MMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* hdl/mms_pkg.sv */
// ----------------------------------------------------------------------------
// mms_pkg
// Types and constants of the motor mode supervisor.
// ----------------------------------------------------------------------------
package mms_pkg;

    localparam int OP_W     = 4;
    localparam int VALUE_W  = 8;
    localparam int MODE_W   = 2;
    localparam int BRAKE_W  = 7;
    localparam int KEY_W    = 2;
    localparam int WARN_W   = 2;

    localparam logic [BRAKE_W-1:0] BRAKE_THRESHOLD_RESET = BRAKE_W'(10);
    localparam logic [WARN_W-1:0]  WARN_HIGH             = WARN_W'(3);
    localparam logic [KEY_W-1:0]   KEY_MAX               = KEY_W'(3);
    localparam logic [KEY_W-1:0]   KEY_ON                = KEY_W'(2);
    localparam logic [BRAKE_W-1:0] BRAKE_MAX             = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF   = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_REGEN = 2'd2
    } mode_t;

    typedef enum logic [OP_W-1:0] {
        OP_AUTH      = 4'd0,
        OP_READY     = 4'd1,
        OP_KEY       = 4'd2,
        OP_BRAKE     = 4'd3,
        OP_GEAR      = 4'd4,
        OP_CONTACTOR = 4'd5,
        OP_REGEN_SW  = 4'd6,
        OP_VEH_WARN  = 4'd7,
        OP_MOT_WARN  = 4'd8,
        OP_STALL     = 4'd9,
        OP_DISCH_INH = 4'd10,
        OP_CHG_INH   = 4'd11
    } op_t;

    // saturate an 8-bit value to a 2-bit level
    function automatic logic [WARN_W-1:0] sat2(input logic [VALUE_W-1:0] v);
        sat2 = (v > VALUE_W'(3)) ? WARN_W'(3) : v[WARN_W-1:0];
    endfunction

endpackage

/* hdl/mms_if.sv */
// ----------------------------------------------------------------------------
// mms_if
// Valid/ready channels of the motor mode supervisor.
// ----------------------------------------------------------------------------
interface mms_item_if;
    logic                         valid;
    logic                         ready;
    logic [mms_pkg::OP_W-1:0]     operation;
    logic [mms_pkg::VALUE_W-1:0]  new_value;

    modport source (output valid, output operation, output new_value, input ready);
    modport sink   (input valid, input operation, input new_value, output ready);
endinterface

interface mms_result_if;
    logic                         valid;
    logic                         ready;
    logic [mms_pkg::MODE_W-1:0]   motor_mode;
    logic                         relay_high;
    logic                         waiting_contactor;

    modport source (output valid, output motor_mode, output relay_high,
                    output waiting_contactor, input ready);
    modport sink   (input valid, input motor_mode, input relay_high,
                    input waiting_contactor, output ready);
endinterface

interface mms_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [mms_pkg::BRAKE_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/motor_mode_supervisor_unit.sv */
// ----------------------------------------------------------------------------
// motor_mode_supervisor_unit
// Keeps shadows of the vehicle signals and derives motor mode, relay level
// and the waiting-for-contactor flag from each signal-change beat.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                     beat
//  item     in   operation[3:0], new_value[7:0]              valid & ready
//  result   out  motor_mode[1:0], relay_high, waiting_cont.  valid & ready
//  cfg      in   data[6:0] = brake_threshold                 valid & ready
//
//  One beat per cycle sustained while results are taken; a result is presented
//  once its item has passed the input register and the result register.
//  Input register -> rule logic -> result register; state updates as an item
//  leaves the input register, so back-to-back items see each other's effects.
//  item.ready drops only when both registers are full and result is stalled.
//  Reset: mode off, relay high, waiting clear, shadows zero, threshold 10.
// ----------------------------------------------------------------------------
module motor_mode_supervisor_unit (
    input  logic               clk,
    input  logic               rst_n,
    mms_item_if.sink           item,
    mms_result_if.source       result,
    mms_cfg_if.sink            cfg
);
    import mms_pkg::*;

    // input stage
    logic                  in_valid_reg;
    logic [OP_W-1:0]       in_op_reg;
    logic [VALUE_W-1:0]    in_value_reg;

    // result stage
    logic                  out_valid_reg;
    mode_t                 out_mode_reg;
    logic                  out_relay_reg;
    logic                  out_wait_reg;

    // supervisor state
    mode_t                 mode_reg, mode_next;
    logic                  wait_reg, wait_next;
    logic                  relay_reg, relay_next;
    logic                  ready_sh_reg, ready_sh_next;
    logic                  cont_sh_reg, cont_sh_next;
    logic                  regen_sh_reg, regen_sh_next;
    logic                  stall_sh_reg, stall_sh_next;
    logic                  dinh_sh_reg, dinh_sh_next;
    logic                  cinh_sh_reg, cinh_sh_next;
    logic [BRAKE_W-1:0]    brake_sh_reg, brake_sh_next;
    logic [WARN_W-1:0]     vwarn_sh_reg, vwarn_sh_next;
    logic [WARN_W-1:0]     mwarn_sh_reg, mwarn_sh_next;
    logic [BRAKE_W-1:0]    thr_reg;

    logic                  advance;
    logic                  flag;
    logic [KEY_W-1:0]      key_sat;
    logic [BRAKE_W-1:0]    brake_sat;
    logic [WARN_W-1:0]     warn_sat;
    logic                  run_ok;
    logic                  regen_ok;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    assign result.valid             = out_valid_reg;
    assign result.motor_mode        = out_mode_reg;
    assign result.relay_high        = out_relay_reg;
    assign result.waiting_contactor = out_wait_reg;

    assign flag      = (in_value_reg != '0);
    assign key_sat   = sat2(in_value_reg);
    assign warn_sat  = sat2(in_value_reg);
    assign brake_sat = (in_value_reg > VALUE_W'(BRAKE_MAX)) ? BRAKE_MAX
                                                            : in_value_reg[BRAKE_W-1:0];

    // interlocks for entering run; none of these shadows change on a run attempt
    assign run_ok   = ready_sh_reg && (vwarn_sh_reg != WARN_HIGH) &&
                      (mwarn_sh_reg != WARN_HIGH) && !stall_sh_reg && !dinh_sh_reg;
    assign regen_ok = (mode_reg == MODE_RUN) && !cinh_sh_reg;

    always_comb
    begin
        mode_next     = mode_reg;
        wait_next     = wait_reg;
        relay_next    = relay_reg;
        ready_sh_next = ready_sh_reg;
        cont_sh_next  = cont_sh_reg;
        regen_sh_next = regen_sh_reg;
        stall_sh_next = stall_sh_reg;
        dinh_sh_next  = dinh_sh_reg;
        cinh_sh_next  = cinh_sh_reg;
        brake_sh_next = brake_sh_reg;
        vwarn_sh_next = vwarn_sh_reg;
        mwarn_sh_next = mwarn_sh_reg;

        case (op_t'(in_op_reg))
            OP_AUTH:
            begin
                if (!flag)
                    mode_next = MODE_OFF;
            end
            OP_READY:
            begin
                ready_sh_next = flag;
                if (!flag)
                    mode_next = MODE_OFF;
            end
            OP_KEY:
            begin
                if (key_sat < KEY_ON)
                begin
                    mode_next  = MODE_OFF;
                    relay_next = 1'b1;
                end
                else if (key_sat == KEY_ON)
                    relay_next = 1'b0;
                else if (run_ok)
                begin
                    if (cont_sh_reg)
                        mode_next = MODE_RUN;
                    else
                        wait_next = 1'b1;
                end
            end
            OP_BRAKE:
            begin
                brake_sh_next = brake_sat;
                if (brake_sat > thr_reg)
                begin
                    if (regen_ok && regen_sh_reg)
                        mode_next = MODE_REGEN;
                end
                else if (brake_sat == '0 && mode_reg == MODE_REGEN && run_ok)
                begin
                    if (cont_sh_reg)
                        mode_next = MODE_RUN;
                    else
                        wait_next = 1'b1;
                end
            end
            OP_GEAR:
            begin
                if (in_value_reg == '0)
                    mode_next = MODE_OFF;
            end
            OP_CONTACTOR:
            begin
                cont_sh_next = flag;
                if (!flag)
                    mode_next = MODE_OFF;
                else
                    wait_next = 1'b0;
            end
            OP_REGEN_SW:
            begin
                regen_sh_next = flag;
                if (flag)
                begin
                    if (regen_ok && brake_sh_reg > thr_reg)
                        mode_next = MODE_REGEN;
                end
                else if (mode_reg == MODE_REGEN && run_ok)
                begin
                    if (cont_sh_reg)
                        mode_next = MODE_RUN;
                    else
                        wait_next = 1'b1;
                end
            end
            OP_VEH_WARN:
            begin
                vwarn_sh_next = warn_sat;
                if (warn_sat == WARN_HIGH)
                    mode_next = MODE_OFF;
            end
            OP_MOT_WARN:
            begin
                mwarn_sh_next = warn_sat;
                if (warn_sat == WARN_HIGH)
                    mode_next = MODE_OFF;
            end
            OP_STALL:
            begin
                stall_sh_next = flag;
                if (flag)
                    mode_next = MODE_OFF;
            end
            OP_DISCH_INH: dinh_sh_next = flag;
            OP_CHG_INH:   cinh_sh_next = flag;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_OFF;
            wait_reg      <= 1'b0;
            relay_reg     <= 1'b1;
            ready_sh_reg  <= 1'b0;
            cont_sh_reg   <= 1'b0;
            regen_sh_reg  <= 1'b0;
            stall_sh_reg  <= 1'b0;
            dinh_sh_reg   <= 1'b0;
            cinh_sh_reg   <= 1'b0;
            brake_sh_reg  <= '0;
            vwarn_sh_reg  <= '0;
            mwarn_sh_reg  <= '0;
            thr_reg       <= BRAKE_THRESHOLD_RESET;
        end
        else
        begin
            if (cfg.valid)
                thr_reg <= cfg.data;
            if (item.ready)
                in_valid_reg <= item.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                mode_reg     <= mode_next;
                wait_reg     <= wait_next;
                relay_reg    <= relay_next;
                ready_sh_reg <= ready_sh_next;
                cont_sh_reg  <= cont_sh_next;
                regen_sh_reg <= regen_sh_next;
                stall_sh_reg <= stall_sh_next;
                dinh_sh_reg  <= dinh_sh_next;
                cinh_sh_reg  <= cinh_sh_next;
                brake_sh_reg <= brake_sh_next;
                vwarn_sh_reg <= vwarn_sh_next;
                mwarn_sh_reg <= mwarn_sh_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_op_reg    <= item.operation;
            in_value_reg <= item.new_value;
        end
        if (advance)
        begin
            out_mode_reg  <= mode_next;
            out_relay_reg <= relay_next;
            out_wait_reg  <= wait_next;
        end
    end

endmodule

/* hdl/mms_checker.sv */
// ----------------------------------------------------------------------------
// mms_checker
// Port-level checks on the motor mode supervisor, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mms_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        item_ready,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic [mms_pkg::MODE_W-1:0]  motor_mode,
    input logic                        relay_high,
    input logic                        waiting_contactor,
    input logic                        cfg_ready
);
    import mms_pkg::*;

    // a stalled result beat keeps its payload
    `MMS_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(motor_mode) && $stable(relay_high) && $stable(waiting_contactor))

    // only the three defined modes are ever reported
    `MMS_ASSERT_NOW(a_mode_code, clk, rst_n, result_valid, motor_mode != MODE_W'(3))

    // input backs up only behind a waiting result
    `MMS_ASSERT_NOW(a_backpressure, clk, rst_n, !item_ready, result_valid && !result_ready)

    // threshold writes never stall
    `MMS_ASSERT_NOW(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)

endmodule

bind motor_mode_supervisor_unit mms_checker u_mms_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_ready        (item.ready),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .motor_mode        (result.motor_mode),
    .relay_high        (result.relay_high),
    .waiting_contactor (result.waiting_contactor),
    .cfg_ready         (cfg.ready)
);
